// File: hw/rtl/clutch_delay_valve_controller_macros.svh
// Assertion macros shared by the clutch delay valve controller RTL
`ifndef CLUTCH_DELAY_VALVE_CONTROLLER_MACROS_SVH
`define CLUTCH_DELAY_VALVE_CONTROLLER_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define CDV_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("clutch delay valve check failed");

// next-cycle implication, clocked on i_clk, off during reset
`define CDV_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("clutch delay valve check failed");

`endif

// File: hw/rtl/cdv_pkg.sv
// Types and register map of the clutch delay valve controller
package cdv_pkg;

    localparam int PADDR_W = 5;

    localparam logic [2:0] REG_CONTROL_ENABLE      = 3'd0;
    localparam logic [2:0] REG_SMART_MODE          = 3'd1;
    localparam logic [2:0] REG_WINDOW_MIN_PRESSURE = 3'd2;
    localparam logic [2:0] REG_WINDOW_MAX_PRESSURE = 3'd3;
    localparam logic [2:0] REG_EXIT_DELAY_TICKS    = 3'd4;
    localparam logic [2:0] REG_EXIT_SPEED          = 3'd5;
    localparam logic [2:0] REG_CLUTCH_EXIT_ENABLE  = 3'd6;

    typedef struct packed {
        logic        launch_condition;
        logic        prelaunch_condition;
        logic [15:0] clutch_pressure;
        logic        pressure_valid;
        logic [15:0] vehicle_speed;
        logic        speed_valid;
        logic        clutch_down;
    } t_in_item;

    typedef struct packed {
        logic solenoid_on;
        logic in_window;
        logic time_exit;
        logic speed_exit;
        logic release_exit;
        logic window_exit;
    } t_out_item;

    typedef struct packed {
        logic        control_enable;
        logic        smart_mode;
        logic [15:0] window_min_pressure;
        logic [15:0] window_max_pressure;
        logic [15:0] exit_delay_ticks;
        logic [15:0] exit_speed;
        logic        clutch_exit_enable;
    } t_cfg;

endpackage

// File: hw/rtl/cdv_core.sv
// Per-tick valve decision logic and controller state
module cdv_core #(
    parameter int TIMER_WIDTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  cdv_pkg::t_in_item i_item,
    input  cdv_pkg::t_cfg     i_cfg,
    output cdv_pkg::t_out_item o_result
);
    import cdv_pkg::*;

    localparam int CMP_W = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;

    logic                   r_valve_active, n_valve_active;
    logic                   r_prev_launch, n_prev_launch;
    logic                   r_prev_pedal_down, n_prev_pedal_down;
    logic [TIMER_WIDTH-1:0] r_ticks_end, n_ticks_end;
    logic [TIMER_WIDTH-1:0] r_ticks_on, n_ticks_on;
    t_out_item              r_flags, n_flags;

    logic        launch;
    logic [15:0] pressure;
    logic [15:0] speed;
    logic        time_on_ok;
    logic        time_end_ok;
    logic [CMP_W-1:0] delay_ext;

    always_comb begin
        launch    = i_item.launch_condition | i_item.prelaunch_condition;
        pressure  = i_item.pressure_valid ? i_item.clutch_pressure : 16'd0;
        speed     = i_item.speed_valid ? i_item.vehicle_speed : 16'd0;
        delay_ext = CMP_W'(i_cfg.exit_delay_ticks);

        n_valve_active    = r_valve_active;
        n_prev_launch     = r_prev_launch;
        n_prev_pedal_down = r_prev_pedal_down;
        n_flags           = r_flags;
        n_ticks_end = (r_ticks_end == '1) ? r_ticks_end : r_ticks_end + TIMER_WIDTH'(1);
        n_ticks_on  = (r_ticks_on == '1) ? r_ticks_on : r_ticks_on + TIMER_WIDTH'(1);
        time_on_ok  = 1'b0;
        time_end_ok = 1'b0;

        if (!i_cfg.control_enable) begin
            n_valve_active    = 1'b0;
            n_prev_launch     = 1'b0;
            n_prev_pedal_down = 1'b0;
        end else begin
            if (r_prev_launch && !launch) begin
                n_ticks_end = '0;
            end
            n_prev_launch = launch;

            n_flags.in_window = (pressure >= i_cfg.window_min_pressure) &&
                                (pressure <= i_cfg.window_max_pressure);

            if (!r_valve_active && launch && (!i_cfg.smart_mode || n_flags.in_window)) begin
                n_valve_active = 1'b1;
                n_ticks_on     = '0;
            end

            time_on_ok  = (n_ticks_on == '1) || (CMP_W'(n_ticks_on) >= delay_ext);
            time_end_ok = (n_ticks_end == '1) || (CMP_W'(n_ticks_end) >= delay_ext);

            if (n_valve_active) begin
                n_flags.time_exit    = i_cfg.smart_mode ? time_on_ok : (!launch && time_end_ok);
                n_flags.speed_exit   = (i_cfg.exit_speed != 16'd0) && (speed >= i_cfg.exit_speed);
                n_flags.release_exit = i_cfg.clutch_exit_enable && r_prev_pedal_down &&
                                       !i_item.clutch_down;
                n_prev_pedal_down    = i_item.clutch_down;
                n_flags.window_exit  = i_cfg.smart_mode && !n_flags.in_window;
                if (n_flags.time_exit || n_flags.speed_exit || n_flags.release_exit ||
                    n_flags.window_exit) begin
                    n_valve_active = 1'b0;
                end
            end
        end
        n_flags.solenoid_on = n_valve_active;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valve_active    <= 1'b0;
            r_prev_launch     <= 1'b0;
            r_prev_pedal_down <= 1'b0;
            r_ticks_end       <= '1;
            r_ticks_on        <= '1;
            r_flags           <= '0;
        end else if (i_step) begin
            r_valve_active    <= n_valve_active;
            r_prev_launch     <= n_prev_launch;
            r_prev_pedal_down <= n_prev_pedal_down;
            r_ticks_end       <= n_ticks_end;
            r_ticks_on        <= n_ticks_on;
            r_flags           <= n_flags;
        end
    end

    assign o_result = n_flags;

endmodule

// File: hw/rtl/clutch_delay_valve_controller.sv
// Clutch delay valve controller top level: register port, handshake and result register
//
// One tick is taken per clock cycle unless a stalled result holds it. Its result appears
// in the output register in the cycle after the input transfer; the whole decision for a
// tick is a single pass of compare and flag logic from the state registers into that
// register. A new tick is taken whenever the output register is empty or its result is
// taken in the same cycle, so ticks flow at one per cycle while the result side keeps up,
// and a stalled result holds the input until that result is taken.
`include "clutch_delay_valve_controller_macros.svh"

module clutch_delay_valve_controller #(
    parameter int TIMER_WIDTH = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  cdv_pkg::t_in_item         i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output cdv_pkg::t_out_item        o_out_data,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [cdv_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import cdv_pkg::*;

    t_cfg      r_cfg;
    logic      r_out_valid;
    t_out_item r_out_data;
    t_out_item result;
    logic      in_xfer;
    logic      cfg_write;
    logic [2:0] reg_idx;
    logic      any_exit;

    assign reg_idx   = paddr[PADDR_W-1:2];
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_CONTROL_ENABLE:      r_cfg.control_enable      <= pwdata[0];
                REG_SMART_MODE:          r_cfg.smart_mode          <= pwdata[0];
                REG_WINDOW_MIN_PRESSURE: r_cfg.window_min_pressure <= pwdata[15:0];
                REG_WINDOW_MAX_PRESSURE: r_cfg.window_max_pressure <= pwdata[15:0];
                REG_EXIT_DELAY_TICKS:    r_cfg.exit_delay_ticks    <= pwdata[15:0];
                REG_EXIT_SPEED:          r_cfg.exit_speed          <= pwdata[15:0];
                REG_CLUTCH_EXIT_ENABLE:  r_cfg.clutch_exit_enable  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_CONTROL_ENABLE:      prdata = {31'd0, r_cfg.control_enable};
            REG_SMART_MODE:          prdata = {31'd0, r_cfg.smart_mode};
            REG_WINDOW_MIN_PRESSURE: prdata = {16'd0, r_cfg.window_min_pressure};
            REG_WINDOW_MAX_PRESSURE: prdata = {16'd0, r_cfg.window_max_pressure};
            REG_EXIT_DELAY_TICKS:    prdata = {16'd0, r_cfg.exit_delay_ticks};
            REG_EXIT_SPEED:          prdata = {16'd0, r_cfg.exit_speed};
            REG_CLUTCH_EXIT_ENABLE:  prdata = {31'd0, r_cfg.clutch_exit_enable};
            default:                 prdata = 32'd0;
        endcase
    end

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_xfer    = i_in_valid && o_in_ready;

    cdv_core #(
        .TIMER_WIDTH(TIMER_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (in_xfer),
        .i_item   (i_in_data),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out_data <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign any_exit = o_out_data.time_exit || o_out_data.speed_exit ||
                      o_out_data.release_exit || o_out_data.window_exit;

    `CDV_ASSERT_NEXT(a_xfer_gives_result, in_xfer, o_out_valid)
    `CDV_ASSERT_NEXT(a_disabled_is_off, in_xfer && !r_cfg.control_enable, !o_out_data.solenoid_on)
    `CDV_ASSERT_NOW(a_on_without_exit, o_out_valid && o_out_data.solenoid_on, !any_exit)

endmodule

// File: verif/tb_top.sv
// Self-checking testbench of the clutch delay valve controller with a tick-level predictor
`timescale 1ns / 1ps

module tb_top;
    import cdv_pkg::*;

    localparam logic [15:0] TIMER_MAX   = 16'hFFFF;
    localparam int unsigned CYCLE_LIMIT = 200000;

    logic                i_clk      = 1'b0;
    logic                i_rst_n    = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    t_in_item            i_in_data  = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    t_out_item           o_out_data;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [PADDR_W-1:0]  paddr   = '0;
    logic [31:0]         pwdata  = '0;
    logic [31:0]         prdata;
    logic                pready;

    clutch_delay_valve_controller u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // shadow configuration and predictor state
    t_cfg        cfg_shadow       = '0;
    t_out_item   p_status         = '0;
    logic        p_prev_launch    = 1'b0;
    logic        p_prev_pedal     = 1'b0;
    logic [15:0] p_tmr_launch_end = TIMER_MAX;
    logic [15:0] p_tmr_on         = TIMER_MAX;

    t_in_item    pending_ticks[$];
    t_out_item   valve_status_q[$];

    int unsigned cyc          = 0;
    int unsigned rx_count     = 0;
    int unsigned mismatch_cnt = 0;
    int unsigned in_gap       = 0;
    int unsigned out_stall    = 0;
    logic        long_hold_done = 1'b0;
    wire         quiet = (cyc % 512) >= 384;

    function automatic logic timer_elapsed(input logic [15:0] t);
        return (t == TIMER_MAX) || (t >= cfg_shadow.exit_delay_ticks);
    endfunction

    function automatic t_out_item predict_valve_status(input t_in_item it);
        logic        launch;
        logic        pedal;
        logic        smart;
        logic [15:0] pres;
        logic [15:0] spd;
        launch = it.launch_condition | it.prelaunch_condition;
        pres   = it.pressure_valid ? it.clutch_pressure : 16'd0;
        spd    = it.speed_valid ? it.vehicle_speed : 16'd0;
        pedal  = it.clutch_down;
        smart  = cfg_shadow.smart_mode;
        if (p_tmr_launch_end != TIMER_MAX) p_tmr_launch_end = p_tmr_launch_end + 16'd1;
        if (p_tmr_on != TIMER_MAX) p_tmr_on = p_tmr_on + 16'd1;
        if (!cfg_shadow.control_enable) begin
            p_status.solenoid_on = 1'b0;
            p_prev_launch = 1'b0;
            p_prev_pedal = 1'b0;
        end else begin
            if (p_prev_launch && !launch) p_tmr_launch_end = 16'd0;
            p_prev_launch = launch;
            p_status.in_window = (pres >= cfg_shadow.window_min_pressure) &&
                                 (pres <= cfg_shadow.window_max_pressure);
            if (!p_status.solenoid_on && launch && (!smart || p_status.in_window)) begin
                p_status.solenoid_on = 1'b1;
                p_tmr_on = 16'd0;
            end
            if (p_status.solenoid_on) begin
                p_status.time_exit = smart ? timer_elapsed(p_tmr_on)
                                           : (!launch && timer_elapsed(p_tmr_launch_end));
                p_status.speed_exit = (cfg_shadow.exit_speed != 16'd0) &&
                                      (spd >= cfg_shadow.exit_speed);
                p_status.release_exit = cfg_shadow.clutch_exit_enable && p_prev_pedal && !pedal;
                p_prev_pedal = pedal;
                p_status.window_exit = smart && !p_status.in_window;
                if (p_status.time_exit || p_status.speed_exit || p_status.release_exit ||
                    p_status.window_exit)
                    p_status.solenoid_on = 1'b0;
            end
        end
        return p_status;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_in_item mk_tick(input logic launch, input logic pre,
                                         input logic [15:0] pres, input logic pres_ok,
                                         input logic [15:0] spd, input logic spd_ok,
                                         input logic pedal);
        t_in_item it;
        it.launch_condition    = launch;
        it.prelaunch_condition = pre;
        it.clutch_pressure     = pres;
        it.pressure_valid      = pres_ok;
        it.vehicle_speed       = spd;
        it.speed_valid         = spd_ok;
        it.clutch_down         = pedal;
        return it;
    endfunction

    function automatic t_in_item noise_tick();
        logic [63:0] raw;
        t_in_item    it;
        raw = {$urandom(), $urandom()};
        it = raw[$bits(t_in_item)-1:0];
        return it;
    endfunction

    function automatic t_in_item shaped_tick(input logic launch);
        t_in_item    it;
        int unsigned mn;
        int unsigned mx;
        it = noise_tick();
        if (launch) begin
            it.launch_condition    = 1'($urandom_range(0, 1));
            it.prelaunch_condition = it.launch_condition ? 1'($urandom_range(0, 1)) : 1'b1;
        end else begin
            it.launch_condition    = 1'b0;
            it.prelaunch_condition = 1'b0;
        end
        mn = cfg_shadow.window_min_pressure;
        mx = cfg_shadow.window_max_pressure;
        if (mn <= mx && $urandom_range(0, 99) < 85)
            it.clutch_pressure = 16'($urandom_range(mn, mx));
        it.pressure_valid = $urandom_range(0, 99) < 95;
        if (cfg_shadow.exit_speed != 16'd0 && $urandom_range(0, 99) < 85)
            it.vehicle_speed = 16'($urandom_range(0, cfg_shadow.exit_speed - 16'd1));
        it.speed_valid = $urandom_range(0, 99) < 90;
        it.clutch_down = $urandom_range(0, 99) < 85;
        return it;
    endfunction

    task automatic queue_launch_run(output int unsigned n);
        int unsigned on_len;
        int unsigned off_len;
        int unsigned d;
        d = (cfg_shadow.exit_delay_ticks > 16'd10) ? 10 : cfg_shadow.exit_delay_ticks;
        on_len  = $urandom_range(1, 6);
        off_len = $urandom_range(0, d + 3);
        for (int unsigned k = 0; k < on_len; k++) pending_ticks.push_back(shaped_tick(1'b1));
        for (int unsigned k = 0; k < off_len; k++) pending_ticks.push_back(shaped_tick(1'b0));
        n = on_len + off_len;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_CONTROL_ENABLE:      cfg_shadow.control_enable      = val[0];
            REG_SMART_MODE:          cfg_shadow.smart_mode          = val[0];
            REG_WINDOW_MIN_PRESSURE: cfg_shadow.window_min_pressure = val[15:0];
            REG_WINDOW_MAX_PRESSURE: cfg_shadow.window_max_pressure = val[15:0];
            REG_EXIT_DELAY_TICKS:    cfg_shadow.exit_delay_ticks    = val[15:0];
            REG_EXIT_SPEED:          cfg_shadow.exit_speed          = val[15:0];
            REG_CLUTCH_EXIT_ENABLE:  cfg_shadow.clutch_exit_enable  = val[0];
            default: ;
        endcase
    endtask

    task automatic set_cfg(input logic en, input logic smart, input logic [15:0] mn,
                           input logic [15:0] mx, input logic [15:0] dly,
                           input logic [15:0] spd, input logic clx);
        write_reg(REG_CONTROL_ENABLE, {31'd0, en});
        write_reg(REG_SMART_MODE, {31'd0, smart});
        write_reg(REG_WINDOW_MIN_PRESSURE, {16'd0, mn});
        write_reg(REG_WINDOW_MAX_PRESSURE, {16'd0, mx});
        write_reg(REG_EXIT_DELAY_TICKS, {16'd0, dly});
        write_reg(REG_EXIT_SPEED, {16'd0, spd});
        write_reg(REG_CLUTCH_EXIT_ENABLE, {31'd0, clx});
    endtask

    // sample at the falling edge so every update of the rising edge has settled
    task automatic wait_idle();
        @(negedge i_clk);
        while (pending_ticks.size() != 0 || i_in_valid || valve_status_q.size() != 0)
            @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic exp_v, input logic act_v);
        if (exp_v !== act_v) begin
            if (mismatch_cnt < 10)
                $display("mismatch %s at result %0d: expected %0b got %0b",
                         name, rx_count, exp_v, act_v);
            mismatch_cnt++;
        end
    endtask

    // driver: present pending ticks, predict each transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap <= 0;
        end else begin
            if (i_in_valid && o_in_ready)
                valve_status_q.push_back(predict_valve_status(i_in_data));
            if (!i_in_valid || o_in_ready) begin
                if (in_gap > 0) begin
                    in_gap <= in_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_ticks.size() != 0) begin
                    i_in_data <= pending_ticks.pop_front();
                    i_in_valid <= 1'b1;
                    in_gap <= quiet ? 0 : pick_gap();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver ready: random stalls plus one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            out_stall <= 0;
        end else if (!long_hold_done && rx_count >= 150 && pending_ticks.size() > 20) begin
            long_hold_done <= 1'b1;
            out_stall <= 300;
            i_out_ready <= 1'b0;
        end else if (out_stall > 0) begin
            out_stall <= out_stall - 1;
            i_out_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 99) < 20) begin
            out_stall <= pick_gap();
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // monitor: compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin
        t_out_item exp_s;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            rx_count <= rx_count + 1;
            if (valve_status_q.size() == 0) begin
                if (mismatch_cnt < 10)
                    $display("unexpected result %0d: got %b", rx_count, o_out_data);
                mismatch_cnt++;
            end else begin
                exp_s = valve_status_q.pop_front();
                check_field("solenoid_on", exp_s.solenoid_on, o_out_data.solenoid_on);
                check_field("in_window", exp_s.in_window, o_out_data.in_window);
                check_field("time_exit", exp_s.time_exit, o_out_data.time_exit);
                check_field("speed_exit", exp_s.speed_exit, o_out_data.speed_exit);
                check_field("release_exit", exp_s.release_exit, o_out_data.release_exit);
                check_field("window_exit", exp_s.window_exit, o_out_data.window_exit);
            end
        end
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        int unsigned phase_items;
        int unsigned n;
        logic [15:0] mn;
        logic [15:0] mx;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset configuration: control disabled
        pending_ticks.push_back(mk_tick(1, 1, 16'hFFFF, 1, 16'hFFFF, 1, 1));
        pending_ticks.push_back(mk_tick(0, 0, 16'd0, 0, 16'd0, 0, 0));
        wait_idle();

        // simple mode: time, release and speed exits, sensor validity
        set_cfg(1, 0, 16'd100, 16'd1000, 16'd2, 16'd5000, 1);
        pending_ticks.push_back(mk_tick(1, 0, 16'd500, 1, 16'd0, 1, 1));
        pending_ticks.push_back(mk_tick(1, 0, 16'd500, 1, 16'd0, 1, 1));
        pending_ticks.push_back(mk_tick(0, 0, 16'd500, 1, 16'd0, 1, 1));
        pending_ticks.push_back(mk_tick(0, 0, 16'd500, 1, 16'd0, 1, 1));
        pending_ticks.push_back(mk_tick(0, 0, 16'd500, 1, 16'd0, 1, 1));
        pending_ticks.push_back(mk_tick(0, 1, 16'd500, 1, 16'd0, 1, 1));
        pending_ticks.push_back(mk_tick(0, 1, 16'd500, 1, 16'd0, 1, 0));
        pending_ticks.push_back(mk_tick(1, 0, 16'd500, 1, 16'hFFFF, 1, 1));
        pending_ticks.push_back(mk_tick(1, 0, 16'd500, 1, 16'hFFFF, 0, 1));
        pending_ticks.push_back(mk_tick(1, 0, 16'hFFFF, 1, 16'd4999, 1, 1));
        pending_ticks.push_back(mk_tick(1, 0, 16'd0, 0, 16'd5000, 1, 1));
        wait_idle();

        // smart mode: window entry, window exit, invalid pressure, time since turn-on
        set_cfg(1, 1, 16'd200, 16'd300, 16'd3, 16'd0, 0);
        pending_ticks.push_back(mk_tick(1, 0, 16'd250, 1, 16'd0, 1, 1));
        pending_ticks.push_back(mk_tick(1, 0, 16'd300, 1, 16'd0, 1, 1));
        pending_ticks.push_back(mk_tick(1, 0, 16'd301, 1, 16'd0, 1, 1));
        pending_ticks.push_back(mk_tick(1, 0, 16'd200, 0, 16'd0, 1, 1));
        pending_ticks.push_back(mk_tick(0, 1, 16'd200, 1, 16'd0, 1, 1));
        pending_ticks.push_back(mk_tick(1, 0, 16'd250, 1, 16'd0, 1, 0));
        pending_ticks.push_back(mk_tick(1, 0, 16'd250, 1, 16'd0, 1, 1));
        pending_ticks.push_back(mk_tick(1, 0, 16'd250, 1, 16'd0, 1, 0));
        wait_idle();

        // inverted window admits nothing
        set_cfg(1, 1, 16'd1000, 16'd100, 16'd3, 16'd0, 0);
        pending_ticks.push_back(mk_tick(1, 0, 16'd500, 1, 16'd0, 1, 1));
        pending_ticks.push_back(mk_tick(1, 1, 16'd100, 1, 16'd0, 1, 1));
        wait_idle();

        set_cfg(0, 1, 16'd0, 16'hFFFF, 16'd0, 16'd1, 1);
        pending_ticks.push_back(mk_tick(1, 0, 16'd500, 1, 16'd0, 1, 1));
        wait_idle();

        for (int phase = 0; phase < 8; phase++) begin
            mn = 16'($urandom_range(0, 2000));
            mx = mn + 16'($urandom_range(0, 3000));
            case (phase)
                0: set_cfg(1, 0, mn, mx, 16'($urandom_range(0, 8)),
                           16'($urandom_range(1000, 9000)), 1);
                1: set_cfg(1, 1, mn, mx, 16'($urandom_range(0, 8)),
                           16'($urandom_range(0, 9000)), 1'($urandom_range(0, 1)));
                2: set_cfg(1, 1, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 1);
                3: set_cfg(1, 0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 0);
                4: set_cfg(0, 1'($urandom_range(0, 1)), mn, mx, 16'($urandom_range(0, 8)),
                           16'($urandom_range(0, 9000)), 1);
                5: set_cfg(1, 1, mn, mn, 16'd1, 16'($urandom_range(0, 9000)), 1);
                6: set_cfg(1, 1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                           16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                           16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
                default: set_cfg(1, 0, mn, mx, 16'($urandom_range(0, 4)), 16'd0, 1);
            endcase
            phase_items = 0;
            while (phase_items < 50) begin
                if ($urandom_range(0, 99) < 80) begin
                    queue_launch_run(n);
                    phase_items += n;
                end else begin
                    pending_ticks.push_back(noise_tick());
                    phase_items++;
                end
            end
            wait_idle();
        end

        repeat (8) @(posedge i_clk);
        if (valve_status_q.size() != 0) mismatch_cnt++;
        if (mismatch_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
